[src/wsm_pkg.sv]
// Shared constants, codes and the result layout of the weight statistics monitor.
`timescale 1ns / 1ps

package wsm_pkg;

  localparam int unsigned MAX_BINS_DEF = 64;
  localparam int unsigned COUNT_BITS   = 40;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // item modes
  localparam logic [1:0] MODE_FILL     = 2'd0;
  localparam logic [1:0] MODE_FILL_REJ = 2'd1;
  localparam logic [1:0] MODE_READ     = 2'd2;
  localparam logic [1:0] MODE_CLEAR    = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_UPPER_LIMIT = 2'd0;
  localparam logic [1:0] CFG_BIN_SCALE   = 2'd1;
  localparam logic [1:0] CFG_BINS_IN_USE = 2'd2;

  localparam logic [30:0] LIMIT_RST = 31'd65536;
  localparam logic [31:0] SCALE_RST = 32'd4194304;
  localparam logic [6:0]  BINS_RST  = 7'd10;

  localparam logic signed [63:0] WSUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] WSUM_MIN = 64'sh8000_0000_0000_0000;
  localparam logic signed [31:0] W_MAX    = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] W_MIN    = 32'sh8000_0000;

  // result item, last field (total_count) in the lowest bits
  typedef struct packed {
    logic                  saturated;
    logic [COUNT_BITS-1:0] bin_count;
    logic [COUNT_BITS-1:0] overflow_count;
    logic [COUNT_BITS-1:0] underflow_count;
    logic signed [31:0]    smallest_weight;
    logic signed [31:0]    largest_weight;
    logic [62:0]           excess_sum;
    logic [63:0]           square_sum;
    logic signed [63:0]    weight_sum;
    logic [COUNT_BITS-1:0] zero_count;
    logic [COUNT_BITS-1:0] accepted_count;
    logic [COUNT_BITS-1:0] total_count;
  } result_t;

endpackage

[src/weight_statistics_monitor.sv]
// Running weight statistics with a histogram kept in an on-chip bin memory.
// Throughput: one item per cycle while the result output is not stalled; a stall
// holds the whole pipeline. The bin memory read-modify-write forwards the last write.
// Stages: input register, multiplies, bin memory read, then update and result register.
// Reset clears all statistics and the per-bin valid bits at once; config takes defaults.
// A clear item empties everything through the valid bits, no sweep.
`timescale 1ns / 1ps

module weight_statistics_monitor
  import wsm_pkg::*;
#(
  parameter int unsigned MAX_BINS = MAX_BINS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [55:0]  s_axis_tdata_i,   // weight[31:0], reject_number[47:32], bin_index[53:48]
  input  logic [1:0]   s_axis_tuser_i,   // mode[1:0]
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // total_count, accepted_count, zero_count, weight_sum, square_sum, excess_sum,
  // largest_weight, smallest_weight, underflow_count, overflow_count, bin_count, saturated
  output logic [495:0] m_axis_tdata_o,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i
);

  localparam int unsigned AW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int unsigned UW = ($clog2(MAX_BINS + 1) > 7) ? $clog2(MAX_BINS + 1) : 7;

  // configuration
  logic [30:0] limit_q;
  logic [31:0] scale_q;
  logic [6:0]  bins_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RST;
      scale_q <= SCALE_RST;
      bins_q  <= BINS_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_UPPER_LIMIT: limit_q <= cfg_data_i[30:0];
        CFG_BIN_SCALE:   scale_q <= cfg_data_i;
        CFG_BINS_IN_USE: bins_q  <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // whole pipeline moves together
  logic adv;
  logic out_valid_q;
  logic in_acc;

  assign adv             = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = adv;
  assign in_acc          = s_axis_tvalid_i && adv;

  // ---------------- stage 1: input register ----------------
  logic               s1_valid_q;
  logic [1:0]         s1_mode_q;
  logic signed [31:0] s1_w_q;
  logic [15:0]        s1_rej_q;
  logic [5:0]         s1_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_mode_q <= s_axis_tuser_i;
      s1_w_q    <= s_axis_tdata_i[31:0];
      s1_rej_q  <= s_axis_tdata_i[47:32];
      s1_idx_q  <= s_axis_tdata_i[53:48];
    end
  end

  logic               s1_under;
  logic               s1_ge_lim;
  logic               s1_gt_lim;
  logic [30:0]        s1_excess;
  logic               s1_accept;
  logic               s1_zero;
  logic signed [63:0] s1_sq;
  logic [62:0]        s1_prod;

  assign s1_under  = s1_w_q[31];
  assign s1_ge_lim = !s1_w_q[31] && (s1_w_q[30:0] >= limit_q);
  assign s1_gt_lim = !s1_w_q[31] && (s1_w_q[30:0] > limit_q);
  assign s1_excess = s1_w_q[30:0] - limit_q;
  assign s1_accept = (s1_mode_q == MODE_FILL) || (s1_w_q <= $signed({16'd0, s1_rej_q}));
  assign s1_zero   = (s1_w_q == 32'sd0);
  assign s1_sq     = s1_w_q * s1_w_q;
  assign s1_prod   = s1_w_q[30:0] * scale_q;

  // ---------------- stage 2: products, bin address ----------------
  logic               s2_valid_q;
  logic [1:0]         s2_mode_q;
  logic signed [31:0] s2_w_q;
  logic [5:0]         s2_idx_q;
  logic               s2_under_q;
  logic               s2_over_q;
  logic               s2_gt_q;
  logic [30:0]        s2_excess_q;
  logic               s2_accept_q;
  logic               s2_zero_q;
  logic [63:0]        s2_sq_q;
  logic [62:0]        s2_prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (adv) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_mode_q   <= s1_mode_q;
      s2_w_q      <= s1_w_q;
      s2_idx_q    <= s1_idx_q;
      s2_under_q  <= s1_under;
      s2_over_q   <= s1_ge_lim;
      s2_gt_q     <= s1_gt_lim;
      s2_excess_q <= s1_excess;
      s2_accept_q <= s1_accept;
      s2_zero_q   <= s1_zero;
      s2_sq_q     <= s1_sq;
      s2_prod_q   <= s1_prod;
    end
  end

  logic [UW-1:0] s2_used;
  logic [30:0]   s2_bin;
  logic          s2_idx_ok;
  logic [AW-1:0] s2_rd_addr;

  // bins in use of zero act as one, beyond the memory as the memory depth
  assign s2_used = (bins_q == 7'd0) ? UW'(1) :
                   (UW'(bins_q) > UW'(MAX_BINS)) ? UW'(MAX_BINS) : UW'(bins_q);
  assign s2_bin  = (s2_prod_q[62:32] >= 31'(s2_used)) ? 31'(s2_used - UW'(1))
                                                      : s2_prod_q[62:32];
  assign s2_idx_ok  = (32'(s2_idx_q) < 32'(MAX_BINS));
  assign s2_rd_addr = (s2_mode_q == MODE_READ) ? AW'(s2_idx_q) : AW'(s2_bin);

  // ---------------- bin memory ----------------
  logic [COUNT_BITS-1:0] bin_mem [MAX_BINS];
  logic [MAX_BINS-1:0]   bin_vld_q;
  logic [COUNT_BITS-1:0] rd_data_q;
  logic                  rd_vld_q;

  // ---------------- stage 3: read data, update ----------------
  logic               s3_valid_q;
  logic [1:0]         s3_mode_q;
  logic signed [31:0] s3_w_q;
  logic               s3_under_q;
  logic               s3_over_q;
  logic               s3_gt_q;
  logic [30:0]        s3_excess_q;
  logic               s3_accept_q;
  logic               s3_zero_q;
  logic [63:0]        s3_sq_q;
  logic [AW-1:0]      s3_addr_q;
  logic               s3_idx_ok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (adv) begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_mode_q   <= s2_mode_q;
      s3_w_q      <= s2_w_q;
      s3_under_q  <= s2_under_q;
      s3_over_q   <= s2_over_q;
      s3_gt_q     <= s2_gt_q;
      s3_excess_q <= s2_excess_q;
      s3_accept_q <= s2_accept_q;
      s3_zero_q   <= s2_zero_q;
      s3_sq_q     <= s2_sq_q;
      s3_addr_q   <= s2_rd_addr;
      s3_idx_ok_q <= s2_idx_ok;
      rd_data_q   <= bin_mem[s2_rd_addr];
      rd_vld_q    <= bin_vld_q[s2_rd_addr];
    end
  end

  // last bin write and last clear, seen by the read that overlapped them
  logic                  fwd_en_q;
  logic                  fwd_clr_q;
  logic [AW-1:0]         fwd_addr_q;
  logic [COUNT_BITS-1:0] fwd_data_q;

  logic                  s3_fill;
  logic                  s3_clear;
  logic                  bin_wr;
  logic [COUNT_BITS-1:0] bin_cur;
  logic [COUNT_BITS-1:0] bin_new;

  assign s3_fill  = s3_valid_q && ((s3_mode_q == MODE_FILL) || (s3_mode_q == MODE_FILL_REJ));
  assign s3_clear = s3_valid_q && (s3_mode_q == MODE_CLEAR);
  assign bin_wr   = s3_fill && !s3_under_q && !s3_over_q;
  assign bin_cur  = fwd_clr_q ? '0 :
                    (fwd_en_q && (fwd_addr_q == s3_addr_q)) ? fwd_data_q :
                    rd_vld_q ? rd_data_q : '0;
  assign bin_new  = (bin_cur == COUNT_MAX) ? bin_cur : bin_cur + 1'b1;

  always_ff @(posedge clk_i) begin
    if (adv && bin_wr) begin
      bin_mem[s3_addr_q] <= bin_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_vld_q <= '0;
      fwd_en_q  <= 1'b0;
      fwd_clr_q <= 1'b0;
    end else if (adv) begin
      if (s3_clear) begin
        bin_vld_q <= '0;
      end else if (bin_wr) begin
        bin_vld_q[s3_addr_q] <= 1'b1;
      end
      fwd_en_q  <= bin_wr;
      fwd_clr_q <= s3_clear;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && bin_wr) begin
      fwd_addr_q <= s3_addr_q;
      fwd_data_q <= bin_new;
    end
  end

  // scalar statistics
  logic [COUNT_BITS-1:0] total_q, total_d;
  logic [COUNT_BITS-1:0] acc_q, acc_d;
  logic [COUNT_BITS-1:0] zero_q, zero_d;
  logic [COUNT_BITS-1:0] under_q, under_d;
  logic [COUNT_BITS-1:0] over_q, over_d;
  logic signed [63:0]    wsum_q, wsum_d;
  logic [63:0]           ssum_q, ssum_d;
  logic [62:0]           esum_q, esum_d;
  logic signed [31:0]    max_q, max_d;
  logic signed [31:0]    min_q, min_d;
  logic                  sat_q, sat_d;
  logic [COUNT_BITS-1:0] bc;

  logic [64:0] wsum_ext;
  logic [64:0] ssum_ext;
  logic [63:0] esum_ext;

  assign wsum_ext = {wsum_q[63], wsum_q} + {{33{s3_w_q[31]}}, s3_w_q};
  assign ssum_ext = {1'b0, ssum_q} + {1'b0, s3_sq_q};
  assign esum_ext = {1'b0, esum_q} + {33'd0, s3_excess_q};

  always_comb begin
    total_d = total_q;
    acc_d   = acc_q;
    zero_d  = zero_q;
    under_d = under_q;
    over_d  = over_q;
    wsum_d  = wsum_q;
    ssum_d  = ssum_q;
    esum_d  = esum_q;
    max_d   = max_q;
    min_d   = min_q;
    sat_d   = sat_q;
    bc      = '0;
    if (s3_valid_q) begin
      case (s3_mode_q)
        MODE_FILL, MODE_FILL_REJ: begin
          if (total_q == COUNT_MAX) sat_d = 1'b1;
          else total_d = total_q + 1'b1;
          if (s3_accept_q) begin
            if (acc_q == COUNT_MAX) sat_d = 1'b1;
            else acc_d = acc_q + 1'b1;
          end
          if (s3_zero_q) begin
            if (zero_q == COUNT_MAX) sat_d = 1'b1;
            else zero_d = zero_q + 1'b1;
          end
          // signed overflow when the two top bits of the extended sum differ
          if (wsum_ext[64] != wsum_ext[63]) begin
            wsum_d = s3_w_q[31] ? WSUM_MIN : WSUM_MAX;
            sat_d  = 1'b1;
          end else begin
            wsum_d = wsum_ext[63:0];
          end
          if (ssum_ext[64]) begin
            ssum_d = '1;
            sat_d  = 1'b1;
          end else begin
            ssum_d = ssum_ext[63:0];
          end
          if (s3_gt_q) begin
            if (esum_ext[63]) begin
              esum_d = '1;
              sat_d  = 1'b1;
            end else begin
              esum_d = esum_ext[62:0];
            end
          end
          if (s3_w_q > max_q) max_d = s3_w_q;
          if (s3_w_q < min_q) min_d = s3_w_q;
          if (s3_under_q) begin
            if (under_q == COUNT_MAX) sat_d = 1'b1;
            else under_d = under_q + 1'b1;
          end else if (s3_over_q) begin
            if (over_q == COUNT_MAX) sat_d = 1'b1;
            else over_d = over_q + 1'b1;
          end else begin
            if (bin_cur == COUNT_MAX) sat_d = 1'b1;
            bc = bin_new;
          end
        end
        MODE_READ: begin
          if (s3_idx_ok_q) bc = bin_cur;
        end
        MODE_CLEAR: begin
          total_d = '0;
          acc_d   = '0;
          zero_d  = '0;
          under_d = '0;
          over_d  = '0;
          wsum_d  = '0;
          ssum_d  = '0;
          esum_d  = '0;
          max_d   = W_MIN;
          min_d   = W_MAX;
          sat_d   = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      acc_q   <= '0;
      zero_q  <= '0;
      under_q <= '0;
      over_q  <= '0;
      wsum_q  <= '0;
      ssum_q  <= '0;
      esum_q  <= '0;
      max_q   <= W_MIN;
      min_q   <= W_MAX;
      sat_q   <= 1'b0;
    end else if (adv) begin
      total_q <= total_d;
      acc_q   <= acc_d;
      zero_q  <= zero_d;
      under_q <= under_d;
      over_q  <= over_d;
      wsum_q  <= wsum_d;
      ssum_q  <= ssum_d;
      esum_q  <= esum_d;
      max_q   <= max_d;
      min_q   <= min_d;
      sat_q   <= sat_d;
    end
  end

  // ---------------- result register ----------------
  result_t result_d;
  result_t out_q;

  always_comb begin
    result_d.total_count     = total_d;
    result_d.accepted_count  = acc_d;
    result_d.zero_count      = zero_d;
    result_d.weight_sum      = wsum_d;
    result_d.square_sum      = ssum_d;
    result_d.excess_sum      = esum_d;
    result_d.largest_weight  = max_d;
    result_d.smallest_weight = min_d;
    result_d.underflow_count = under_d;
    result_d.overflow_count  = over_d;
    result_d.bin_count       = bc;
    result_d.saturated       = sat_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s3_valid_q) begin
      out_q <= result_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q;

  // ---------------- assertions ----------------
  assert property (@(posedge clk_i) disable iff (!rst_ni) acc_q <= total_q)
    else $error("accepted count exceeds total count");

  assert property (@(posedge clk_i) disable iff (!rst_ni) zero_q <= acc_q)
    else $error("zero count exceeds accepted count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_en_q |-> bin_vld_q[fwd_addr_q])
    else $error("forwarded bin write not marked valid");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && s3_clear) |=> (total_q == '0) && (bin_vld_q == '0) && !sat_q && !fwd_en_q)
    else $error("clear item left statistics behind");

endmodule

[test/weight_statistics_monitor_test.sv]
// Self-checking stream testbench for the weight statistics monitor.
`timescale 1ns / 1ps

module weight_statistics_monitor_test;
  import wsm_pkg::*;

  localparam int WATCHDOG_CYCLES = 3000;
  localparam int HOLD_CYCLES     = 150;

  logic         clk_i = 1'b0;
  logic         rst_ni;
  logic         s_axis_tvalid_i;
  logic         s_axis_tready_o;
  logic [55:0]  s_axis_tdata_i;   // weight, reject_number, bin_index, zero pad
  logic [1:0]   s_axis_tuser_i;   // mode
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i;
  logic [495:0] m_axis_tdata_o;   // result_t, total_count in the lowest bits
  logic         cfg_valid_i;
  logic         cfg_ready_o;
  logic [1:0]   cfg_index_i;
  logic [31:0]  cfg_data_i;

  weight_statistics_monitor uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // predicted monitor state
  logic [COUNT_BITS-1:0] cnt_total, cnt_accepted, cnt_zero, cnt_under, cnt_over;
  logic [COUNT_BITS-1:0] bin_tally [MAX_BINS_DEF];
  logic signed [63:0]    wsum;
  logic [63:0]           sqsum;
  logic [62:0]           excess;
  logic signed [31:0]    wmax, wmin;
  logic                  sat_seen;
  logic [30:0]           lim_reg;
  logic [31:0]           scale_reg;
  logic [6:0]            bins_reg;

  result_t stats_expected_q [$];
  int      mismatches;
  int      send_idle_pct;
  int      recv_idle_pct;
  int      holds_asked;
  int      holds_done;

  function automatic void clear_statistics();
    cnt_total    = '0;
    cnt_accepted = '0;
    cnt_zero     = '0;
    cnt_under    = '0;
    cnt_over     = '0;
    foreach (bin_tally[i]) bin_tally[i] = '0;
    wsum     = '0;
    sqsum    = '0;
    excess   = '0;
    wmax     = W_MIN;
    wmin     = W_MAX;
    sat_seen = 1'b0;
  endfunction

  function automatic logic [COUNT_BITS-1:0] bump_count(logic [COUNT_BITS-1:0] c);
    if (c == COUNT_MAX) begin
      sat_seen = 1'b1;
      return c;
    end
    return c + 1'b1;
  endfunction

  function automatic result_t update_statistics(logic [1:0] mode, logic signed [31:0] w,
                                                logic [15:0] rej, logic [5:0] idx);
    result_t               r;
    longint                wl, lim;
    logic [64:0]           wsum_ext, sq_ext;
    logic [63:0]           sq, ex_ext, prod;
    int unsigned           used, bin;
    logic [COUNT_BITS-1:0] bc;
    wl  = w;
    lim = lim_reg;
    bc  = '0;
    if (mode == MODE_FILL || mode == MODE_FILL_REJ) begin
      used = (bins_reg == 0) ? 1 : (bins_reg > MAX_BINS_DEF) ? MAX_BINS_DEF : bins_reg;
      cnt_total = bump_count(cnt_total);
      if (mode == MODE_FILL || wl <= longint'(rej)) cnt_accepted = bump_count(cnt_accepted);
      if (w == 0) cnt_zero = bump_count(cnt_zero);
      // 65-bit sum: top two bits differ on signed overflow
      wsum_ext = {wsum[63], wsum} + {{33{w[31]}}, w};
      if (wsum_ext[64] != wsum_ext[63]) begin
        wsum     = wsum_ext[64] ? WSUM_MIN : WSUM_MAX;
        sat_seen = 1'b1;
      end else begin
        wsum = wsum_ext[63:0];
      end
      sq     = wl * wl;
      sq_ext = {1'b0, sqsum} + {1'b0, sq};
      if (sq_ext[64]) begin
        sqsum    = '1;
        sat_seen = 1'b1;
      end else begin
        sqsum = sq_ext[63:0];
      end
      if (wl > lim) begin
        ex_ext = {1'b0, excess} + 64'(wl - lim);
        if (ex_ext[63]) begin
          excess   = '1;
          sat_seen = 1'b1;
        end else begin
          excess = ex_ext[62:0];
        end
      end
      if (w > wmax) wmax = w;
      if (w < wmin) wmin = w;
      if (wl < 0) begin
        cnt_under = bump_count(cnt_under);
      end else if (wl >= lim) begin
        cnt_over = bump_count(cnt_over);
      end else begin
        prod = 64'(w[30:0]) * 64'(scale_reg);
        bin  = prod[63:32];
        if (bin >= used) bin = used - 1;
        bin_tally[bin] = bump_count(bin_tally[bin]);
        bc = bin_tally[bin];
      end
    end else if (mode == MODE_READ) begin
      bc = bin_tally[idx];
    end else begin
      clear_statistics();
    end
    r.total_count     = cnt_total;
    r.accepted_count  = cnt_accepted;
    r.zero_count      = cnt_zero;
    r.weight_sum      = wsum;
    r.square_sum      = sqsum;
    r.excess_sum      = excess;
    r.largest_weight  = wmax;
    r.smallest_weight = wmin;
    r.underflow_count = cnt_under;
    r.overflow_count  = cnt_over;
    r.bin_count       = bc;
    r.saturated       = sat_seen;
    return r;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
    end
  endfunction

  // result checker
  always @(posedge clk_i) begin
    result_t got, want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = m_axis_tdata_o;
      if (stats_expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("%0t: unexpected result item %h", $time, got);
      end else begin
        want = stats_expected_q.pop_front();
        check_field("total_count", want.total_count, got.total_count);
        check_field("accepted_count", want.accepted_count, got.accepted_count);
        check_field("zero_count", want.zero_count, got.zero_count);
        check_field("weight_sum", want.weight_sum, got.weight_sum);
        check_field("square_sum", want.square_sum, got.square_sum);
        check_field("excess_sum", want.excess_sum, got.excess_sum);
        check_field("largest_weight", want.largest_weight, got.largest_weight);
        check_field("smallest_weight", want.smallest_weight, got.smallest_weight);
        check_field("underflow_count", want.underflow_count, got.underflow_count);
        check_field("overflow_count", want.overflow_count, got.overflow_count);
        check_field("bin_count", want.bin_count, got.bin_count);
        check_field("saturated", want.saturated, got.saturated);
      end
    end
  end

  // result ready: random idling, or a long hold-off on request
  initial begin
    m_axis_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (holds_done != holds_asked) begin
        m_axis_tready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        holds_done++;
      end else begin
        m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // watchdog on cycles with no handshake on any channel
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_CYCLES) begin
      @(posedge clk_i);
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
          (cfg_valid_i && cfg_ready_o))
        quiet = 0;
      else
        quiet++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  task automatic send_item(logic [1:0] mode, logic signed [31:0] w, logic [15:0] rej,
                           logic [5:0] idx);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {2'b00, idx, rej, w};
    s_axis_tuser_i  <= mode;
    do @(posedge clk_i); while (!s_axis_tready_o);
    stats_expected_q.push_back(update_statistics(mode, w, rej, idx));
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (stats_expected_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_UPPER_LIMIT: lim_reg   = data[30:0];
      CFG_BIN_SCALE:   scale_reg = data;
      CFG_BINS_IN_USE: bins_reg  = data[6:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic signed [31:0] random_weight();
    longint v, lim;
    lim = lim_reg;
    case ($urandom_range(9))
      0, 1, 2: return $urandom();
      3, 4, 5: v = longint'($urandom_range(32'(lim + lim / 2))) - lim / 4;
      6, 7:    return $urandom_range(65535);
      8:       v = lim + longint'($urandom_range(4)) - 2;
      default: begin
        case ($urandom_range(4))
          0: return 0;
          1: return W_MAX;
          2: return W_MIN;
          3: return 1;
          default: return -1;
        endcase
      end
    endcase
    if (v > longint'(W_MAX)) v = W_MAX;
    return v[31:0];
  endfunction

  task automatic random_items(int n);
    logic [1:0] mode;
    int         pick;
    repeat (n) begin
      pick = $urandom_range(99);
      if (pick < 45)      mode = MODE_FILL;
      else if (pick < 80) mode = MODE_FILL_REJ;
      else if (pick < 97) mode = MODE_READ;
      else                mode = MODE_CLEAR;
      send_item(mode, random_weight(), 16'($urandom_range(65535)), 6'($urandom_range(63)));
    end
  endtask

  // reset settings: bins are w >> 10, clamped to bin 9
  task automatic test_directed();
    send_item(MODE_FILL, 0, 0, 0);
    send_item(MODE_FILL, 1024, 16'hFFFF, 63);
    send_item(MODE_FILL, 32768, 0, 0);
    send_item(MODE_FILL, 65535, 0, 0);
    send_item(MODE_FILL, 65536, 0, 0);       // at limit: overflow, no excess
    send_item(MODE_FILL, 65537, 0, 0);
    send_item(MODE_FILL, -1, 0, 0);
    send_item(MODE_FILL, W_MAX, 0, 0);
    send_item(MODE_FILL, W_MIN, 0, 0);
    send_item(MODE_FILL_REJ, 100, 100, 0);   // equal to reject number: accepted
    send_item(MODE_FILL_REJ, 101, 100, 0);
    send_item(MODE_FILL_REJ, -5, 0, 0);
    send_item(MODE_FILL_REJ, 0, 16'hFFFF, 0);
    send_item(MODE_READ, 0, 0, 0);
    send_item(MODE_READ, 0, 0, 1);
    send_item(MODE_READ, 0, 0, 9);
    send_item(MODE_READ, -1, 16'hFFFF, 63);
    send_item(MODE_CLEAR, 0, 0, 0);
    send_item(MODE_READ, 0, 0, 9);
    // four squares of the most negative weight overflow the square sum
    repeat (4) send_item(MODE_FILL_REJ, W_MIN, 16'hFFFF, 0);
    send_item(MODE_FILL, 2048, 0, 0);
    send_item(MODE_CLEAR, W_MAX, 16'hFFFF, 63);
    send_item(MODE_FILL, 2048, 0, 0);
    wait_idle();
  endtask

  task automatic test_reset_settings();
    random_items(300);
    wait_idle();
  endtask

  task automatic test_config_extremes();
    write_reg(CFG_UPPER_LIMIT, 32'd1);
    write_reg(CFG_BIN_SCALE, 32'd0);
    write_reg(CFG_BINS_IN_USE, 32'd1);
    random_items(100);
    wait_idle();
    send_idle_pct = 54;
    recv_idle_pct = 20;
    write_reg(CFG_UPPER_LIMIT, 32'h7FFF_FFFF);
    write_reg(CFG_BIN_SCALE, 32'hFFFF_FFFF);
    write_reg(CFG_BINS_IN_USE, 32'd64);
    random_items(150);
    wait_idle();
  endtask

  // bins in use out of range and a zero upper limit
  task automatic test_odd_settings();
    write_reg(CFG_UPPER_LIMIT, 32'(LIMIT_RST));
    write_reg(CFG_BIN_SCALE, SCALE_RST);
    write_reg(CFG_BINS_IN_USE, 32'd0);
    send_item(MODE_FILL, 0, 0, 0);
    send_item(MODE_FILL, 30000, 0, 0);
    send_item(MODE_READ, 0, 0, 0);
    wait_idle();
    write_reg(CFG_BINS_IN_USE, 32'd127);
    send_item(MODE_FILL, 65535, 0, 0);
    send_item(MODE_READ, 0, 0, 63);
    wait_idle();
    write_reg(CFG_UPPER_LIMIT, 32'd0);
    send_item(MODE_FILL, 0, 0, 0);
    send_item(MODE_FILL, 5, 0, 0);
    send_item(MODE_FILL_REJ, -3, 0, 0);
    send_item(MODE_READ, 0, 0, 0);
    wait_idle();
    // 16 bins over [0, 4.0)
    write_reg(CFG_UPPER_LIMIT, 32'd262144);
    write_reg(CFG_BIN_SCALE, 32'd262144);
    write_reg(CFG_BINS_IN_USE, 32'd16);
    random_items(150);
    wait_idle();
  endtask

  task automatic test_no_idling();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_items(200);
  endtask

  task automatic test_back_pressure();
    holds_asked++;
    random_items(60);
    wait_idle();
    random_items(100);
  endtask

  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = MODE_FILL;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = CFG_UPPER_LIMIT;
    cfg_data_i      = '0;
    mismatches      = 0;
    holds_asked     = 0;
    holds_done      = 0;
    send_idle_pct   = 20;
    recv_idle_pct   = 54;
    lim_reg         = LIMIT_RST;
    scale_reg       = SCALE_RST;
    bins_reg        = BINS_RST;
    clear_statistics();
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_reset_settings();
    test_config_extremes();
    test_odd_settings();
    test_no_idling();
    test_back_pressure();

    wait_idle();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && stats_expected_q.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
